### sv/aabb_pkg.sv
// Shared types and constants for the pair overlap broadphase.
package aabb_pkg;
   localparam int AXES = 3;
   localparam int IDX_BITS = 6;
   localparam int MASK_BITS = 64;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ,
      ST_SCAN,
      ST_EMIT
   } state_type;
endpackage

### sv/aabb_store.sv
// Object store: one synchronous memory holding bounds and report flag of each object.
module aabb_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 193
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/aabb_pair_overlap_broadphase.sv
// Top level of the pair overlap broadphase.
// Objects arrive on the req_ channel, one word per object, and are accepted at one
// per cycle while the block loads. The word with req_last_object set ends the set.
// Objects beyond MAX_OBJECTS are dropped, but their last mark still ends the set.
// After the last word the block scans the store: for each object i it holds i's
// record and reads every later object j from the store read port, one pair per
// cycle. Each row passes through a read state, a capture of i's record, one
// compare per later object and an emit state. Each finished row leaves on the
// rsp_ channel as one word with its index, partner mask and a last_row mark on
// the final row; a row waits in the output register while rsp_stall is high and
// the scan pauses with it. req_stall is high from the last word until the final
// row enters the output register. A set of n objects yields exactly n rows, or
// MAX_OBJECTS rows when objects were dropped.
// Reset clears the object count and the control state; the store is not cleared.
module aabb_pair_overlap_broadphase
   import aabb_pkg::*;
#(
   parameter int MAX_OBJECTS = 64,
   parameter int COORD_BITS  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [31:0]        req_u_low,
   input  logic signed [31:0]        req_u_high,
   input  logic signed [31:0]        req_v_low,
   input  logic signed [31:0]        req_v_high,
   input  logic signed [31:0]        req_w_low,
   input  logic signed [31:0]        req_w_high,
   input  logic                      req_wants_report,
   input  logic                      req_last_object,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [aabb_pkg::IDX_BITS-1:0]  rsp_object_index,
   output logic [aabb_pkg::MASK_BITS-1:0] rsp_partner_mask,
   output logic                      rsp_last_row
);
   localparam int AW = $clog2(MAX_OBJECTS);
   localparam int CW = $clog2(MAX_OBJECTS + 1);
   localparam int REC = 6 * COORD_BITS + 1;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [REC-1:0] base_ff, base_in;
   logic [MASK_BITS-1:0] mask_ff, mask_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [MASK_BITS-1:0] rsp_mask_ff, rsp_mask_in;
   logic rsp_last_ff, rsp_last_in;

   logic wr_en;
   logic [REC-1:0] wr_data, rd_data;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] rd_ptr;
   logic req_take, hit, col_pending_ff, col_pending_in;

   function automatic logic [COORD_BITS-1:0] bias(input logic [31:0] x);
      logic [COORD_BITS-1:0] t;
      t = x[COORD_BITS-1:0];
      t[COORD_BITS-1] = ~t[COORD_BITS-1];
      return t;
   endfunction

   assign wr_data = {bias(req_u_low), bias(req_u_high), bias(req_v_low),
                     bias(req_v_high), bias(req_w_low), bias(req_w_high),
                     req_wants_report};
   assign req_take = req_valid && !req_stall;
   assign wr_en = req_take && (count_ff < CW'(MAX_OBJECTS));
   assign req_stall = (state_ff != ST_LOAD);
   assign rd_addr = rd_ptr[AW-1:0];

   aabb_store #(.DEPTH(MAX_OBJECTS), .WIDTH(REC)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic ov;
      ov = (base_ff[0] | rd_data[0]);
      for (int k = 0; k < AXES; k++) begin
         if (rd_data[1 + (2*k)*COORD_BITS +: COORD_BITS] <
             base_ff[1 + (2*k+1)*COORD_BITS +: COORD_BITS]) ov = 1'b0;
         if (base_ff[1 + (2*k)*COORD_BITS +: COORD_BITS] <
             rd_data[1 + (2*k+1)*COORD_BITS +: COORD_BITS]) ov = 1'b0;
      end
      hit = ov;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      row_in = row_ff;
      col_in = col_ff;
      base_in = base_ff;
      mask_in = mask_ff;
      col_pending_in = 1'b0;
      rd_ptr = row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_mask_in = rsp_mask_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (wr_en) count_in = count_ff + 1'b1;
            if (req_take && req_last_object) begin
               row_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_ptr = row_ff;
            col_in = row_ff + 1'b1;
            mask_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!col_pending_ff) base_in = rd_data;
            else if (hit) mask_in[col_ff[AW-1:0] - 1'b1] = 1'b1;
            if (col_pending_ff && col_ff >= count_ff) begin
               state_in = ST_EMIT;
            end else if (!col_pending_ff && col_ff >= count_ff) begin
               state_in = ST_EMIT;
            end else begin
               rd_ptr = col_ff;
               col_pending_in = 1'b1;
               col_in = col_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = IDX_BITS'(row_ff);
               rsp_mask_in = mask_ff;
               rsp_last_in = (row_ff + 1'b1 == count_ff);
               row_in = row_ff + 1'b1;
               if (row_ff + 1'b1 == count_ff) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         col_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         col_pending_ff <= col_pending_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      base_ff <= base_in;
      mask_ff <= mask_in;
      rsp_index_ff <= rsp_index_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_object_index = rsp_index_ff;
   assign rsp_partner_mask = rsp_mask_ff;
   assign rsp_last_row = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_OBJECTS)) else $error("object count overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_partner_mask))
      else $error("stalled row changed");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> !wr_en) else $error("store written during scan");
   a_pending_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |-> !col_pending_ff)
      else $error("column read pending outside the scan");
endmodule

### verif/tb_aabb_pair_overlap_broadphase.sv
// Self-checking testbench for the pair overlap broadphase: object sets in, partner rows out.
`timescale 1ns / 1ps
module tb_aabb_pair_overlap_broadphase;
   import aabb_pkg::*;

   localparam int MAX_OBJECTS = 64;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic [AXES-1:0][31:0] lo;
      logic [AXES-1:0][31:0] hi;
      logic                  rep;
      logic                  last;
   } object_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  idx;
      logic [MASK_BITS-1:0] mask;
      logic                 last;
   } row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_u_low, req_u_high, req_v_low, req_v_high, req_w_low, req_w_high;
   logic req_wants_report;
   logic req_last_object;
   logic rsp_valid;
   logic rsp_stall;
   logic [IDX_BITS-1:0] rsp_object_index;
   logic [MASK_BITS-1:0] rsp_partner_mask;
   logic rsp_last_row;

   object_type loaded_objects [MAX_OBJECTS];
   int      loaded_count;
   row_type pending_rows [$];
   int      mismatches;
   int      words_sent;
   int      rows_checked;
   int      sets_sent;
   int      cycles;
   int      gap_pct;
   int      stall_pct;
   int      hold_cycles;

   aabb_pair_overlap_broadphase DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_u_low(req_u_low), .req_u_high(req_u_high),
      .req_v_low(req_v_low), .req_v_high(req_v_high),
      .req_w_low(req_w_low), .req_w_high(req_w_high),
      .req_wants_report(req_wants_report), .req_last_object(req_last_object),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_object_index(rsp_object_index), .rsp_partner_mask(rsp_partner_mask),
      .rsp_last_row(rsp_last_row)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d rows pending", cycles, pending_rows.size());
         $display("** aabb_pair_overlap_broadphase: FAILED **");
         $finish;
      end
   end

   function automatic bit boxes_touch(object_type a, object_type b);
      for (int k = 0; k < AXES; k++) begin
         if ($signed(a.hi[k]) < $signed(b.lo[k]) || $signed(b.hi[k]) < $signed(a.lo[k]))
            return 0;
      end
      return 1;
   endfunction

   function automatic void predict_rows(object_type o);
      row_type r;
      if (loaded_count < MAX_OBJECTS) begin
         loaded_objects[loaded_count] = o;
         loaded_count++;
      end
      if (o.last) begin
         for (int i = 0; i < loaded_count; i++) begin
            r.idx = IDX_BITS'(i);
            r.mask = '0;
            r.last = (i + 1 == loaded_count);
            for (int j = i + 1; j < loaded_count; j++) begin
               if ((loaded_objects[i].rep | loaded_objects[j].rep) &&
                   boxes_touch(loaded_objects[i], loaded_objects[j]))
                  r.mask[j] = 1'b1;
            end
            pending_rows.push_back(r);
         end
         loaded_count = 0;
         sets_sent++;
      end
   endfunction

   // Sends one word; the caller is at a rising edge. Valid stays high afterward.
   task automatic send_object(object_type o);
      bit taken;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_u_low <= o.lo[0];
      req_u_high <= o.hi[0];
      req_v_low <= o.lo[1];
      req_v_high <= o.hi[1];
      req_w_low <= o.lo[2];
      req_w_high <= o.hi[2];
      req_wants_report <= o.rep;
      req_last_object <= o.last;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predict_rows(o);
      words_sent++;
   endtask

   function automatic object_type make_object(int base, bit rep, bit last);
      object_type o;
      int lo;
      for (int k = 0; k < AXES; k++) begin
         if ($urandom_range(15) == 0) begin
            o.lo[k] = $urandom;
            o.hi[k] = $urandom;
         end else begin
            lo = base + $urandom_range(0, 60000);
            o.lo[k] = lo;
            o.hi[k] = lo + $urandom_range(0, 40000);
         end
      end
      o.rep = rep;
      o.last = last;
      return o;
   endfunction

   task automatic send_random_set(int n);
      int base;
      base = int'($urandom_range(0, 32'h7fff_0000)) - 32'sh3fff_8000;
      for (int i = 0; i < n; i++)
         send_object(make_object(base, 1'($urandom_range(1)), i == n - 1));
   endtask

   task automatic set_idling(int phase);
      case (phase)
         0: begin gap_pct = 0; stall_pct = 0; end
         1: begin gap_pct = 63; stall_pct = 0; end
         2: begin gap_pct = 0; stall_pct = 63; end
         default: begin gap_pct = 35; stall_pct = 35; end
      endcase
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (!reset && $urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      bit      taken;
      row_type seen;
      row_type want;
      forever begin
         @(negedge clock);
         taken = rsp_valid && !rsp_stall && !reset;
         seen = {rsp_object_index, rsp_partner_mask, rsp_last_row};
         @(posedge clock);
         if (taken) begin
            if (pending_rows.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("Unexpected row: index %0d mask %h last %b",
                           seen.idx, seen.mask, seen.last);
            end else begin
               want = pending_rows.pop_front();
               rows_checked++;
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("Row mismatch: expected index %0d mask %h last %b, got %0d %h %b",
                              want.idx, want.mask, want.last, seen.idx, seen.mask, seen.last);
               end
            end
         end
      end
   end

   task automatic test_extremes();
      object_type o;
      o.lo = {AXES{32'h8000_0000}};
      o.hi = {AXES{32'h7fff_ffff}};
      o.rep = 1'b1;
      o.last = 1'b1;
      send_object(o);
      o.last = 1'b0;
      send_object(o);
      o.rep = 1'b0;
      send_object(o);
      o.lo = {AXES{32'h7fff_ffff}};
      send_object(o);
      o.lo = {AXES{32'h0000_0010}};
      o.hi = {AXES{32'h0000_0010}};
      o.rep = 1'b1;
      send_object(o);
      o.lo = {AXES{32'h0000_0011}};
      o.hi = {AXES{32'hffff_fff0}};
      send_object(o);
      o.lo = {AXES{32'hffff_ffff}};
      o.hi = {AXES{32'h0000_0000}};
      o.rep = 1'b0;
      o.last = 1'b1;
      send_object(o);
   endtask

   task automatic test_report_flags();
      object_type o;
      for (int i = 0; i < 8; i++) begin
         o.lo = {AXES{32'hffff_0000 + i}};
         o.hi = {AXES{32'h0001_0000 - i}};
         o.lo[i % AXES] = (i == 5) ? 32'h0002_0000 : o.lo[i % AXES];
         o.rep = (i == 2 || i == 6);
         o.last = (i == 7);
         send_object(o);
      end
   endtask

   task automatic test_overflow();
      int base;
      base = -1000;
      for (int i = 0; i < MAX_OBJECTS + 3; i++)
         send_object(make_object(base, i % 3 == 0, i == MAX_OBJECTS + 2));
   endtask

   task automatic test_backpressure();
      @(negedge clock);
      hold_cycles = 3000;
      @(posedge clock);
      send_random_set(12);
      send_random_set(5);
   endtask

   task automatic test_random(int words);
      int target;
      target = words_sent + words;
      while (words_sent < target) begin
         set_idling((words_sent * 4 / (target + 1)) % 4);
         if ($urandom_range(19) == 0)
            send_random_set($urandom_range(40, MAX_OBJECTS));
         else
            send_random_set($urandom_range(1, 10));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_u_low = '0; req_u_high = '0;
      req_v_low = '0; req_v_high = '0;
      req_w_low = '0; req_w_high = '0;
      req_wants_report = 1'b0;
      req_last_object = 1'b0;
      loaded_count = 0;
      mismatches = 0;
      words_sent = 0;
      rows_checked = 0;
      sets_sent = 0;
      cycles = 0;
      hold_cycles = 0;
      set_idling(0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_report_flags();
      test_overflow();
      set_idling(3);
      test_backpressure();
      test_random(370);
      set_idling(0);
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d objects in %0d sets and checked %0d partner rows,", words_sent,
               sets_sent, rows_checked);
      $display("including full sets, dropped objects and a long output stall.");
      if (mismatches == 0 && pending_rows.size() == 0) begin
         $display("** aabb_pair_overlap_broadphase: PASSED **");
      end else begin
         $display("%0d mismatches, %0d rows missing", mismatches, pending_rows.size());
         $display("** aabb_pair_overlap_broadphase: FAILED **");
      end
      $finish;
   end
endmodule
